>>> sv/assert_macros.svh
// Assertion macros for the sketch RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with reset disable.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> sv/hll_pkg.sv
// Package for the HyperLogLog sketch: sizes, codes and state type.
package hll_pkg;

  localparam int MaxIndexBits = 8;
  localparam int Buckets      = 1 << MaxIndexBits;
  localparam int AddrW        = MaxIndexBits;
  localparam int RegW         = 7;
  localparam int HashBits     = 64;
  localparam int FracBits     = 64;
  localparam int SumW         = FracBits + MaxIndexBits + 1;
  localparam int NumW         = 16 + 48 + 2 * MaxIndexBits;
  localparam int DivSteps     = NumW;
  localparam int DivCntW      = $clog2(DivSteps);
  localparam int IbW          = 4;
  localparam int ConstW       = 16;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_EST = 1'b1;

  localparam logic CFG_INDEX_BITS = 1'b0;
  localparam logic CFG_EST_CONST  = 1'b1;

  localparam logic [IbW-1:0]    IndexBitsReset = 4'd4;
  localparam logic [ConstW-1:0] EstConstReset  = 16'd52037;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } state_t;

  // Trailing zeros of the counted low bits; all-zero gives the counted width.
  function automatic logic [RegW-1:0] tz_count(input logic [HashBits-1:0] h,
                                               input logic [RegW-1:0] counted);
    logic [RegW-1:0] cnt;
    cnt = counted;
    for (int i = HashBits - 1; i >= 0; i--) begin
      if (h[i]) cnt = RegW'(i);
    end
    return cnt;
  endfunction

endpackage

>>> sv/hyperloglog_sketch_unit.sv
// Top level of the HyperLogLog sketch: bucket store, summing walk and divider.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------
//  s_*     | in  | s_tvalid/s_tready  | s_tdata=hash_value, s_tuser=op
//  m_*     | out | m_tvalid/m_tready  | m_tdata=estimate, m_tuser=saturated
//  cfg_*   | in  | cfg_we             | cfg_addr=register, cfg_data=value
//
// An add does one bucket RAM read, then compare and write back.
// An estimate (index_bits capped at 8) does one RAM read per bucket, then an
// 80-step restoring divider, one quotient bit a cycle.
// Reset clears control state and the per-bucket valid flags;
// a bucket without its flag reads as zero, so no clearing sweep is needed.
// A finished estimate waits in the output register; the block keeps taking
// words while it waits and stalls only a second estimate at its end.
`include "assert_macros.svh"

module hyperloglog_sketch_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [63:0] hash_value
  input  logic        s_tuser,   // [0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [63:0] estimate
  output logic        m_tuser,   // [0] saturated
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_data
);

  hll_pkg::state_t state, state_next;

  logic [hll_pkg::IbW-1:0]    index_bits;
  logic [hll_pkg::ConstW-1:0] estimate_constant;

  logic [hll_pkg::AddrW-1:0]  hold_idx;
  logic [hll_pkg::RegW-1:0]   hold_cnt;
  logic [hll_pkg::AddrW-1:0]  walk_idx;
  logic [hll_pkg::AddrW-1:0]  walk_last;
  logic [hll_pkg::SumW-1:0]   sum;
  logic [hll_pkg::SumW-1:0]   rem;
  logic [hll_pkg::NumW-1:0]   numq;
  logic [hll_pkg::DivCntW-1:0] div_cnt;
  logic [hll_pkg::Buckets-1:0] valid;
  logic                        valid_rd;

  logic                        ram_we;
  logic [hll_pkg::AddrW-1:0]   ram_raddr;
  logic [hll_pkg::RegW-1:0]    ram_rdata;
  logic [hll_pkg::RegW-1:0]    cur_reg;

  logic [hll_pkg::IbW-1:0]     eff_ib;
  logic [hll_pkg::RegW-1:0]    counted;
  logic [63:0]                 hash_low;
  logic [hll_pkg::AddrW-1:0]   in_idx;
  logic [hll_pkg::RegW-1:0]    in_cnt;
  logic [hll_pkg::SumW-1:0]    term;
  logic [hll_pkg::SumW:0]      div_r2;
  logic [hll_pkg::SumW:0]      div_diff;
  logic                        div_bit;
  logic                        est_sat;
  logic                        out_load;
  logic                        in_acc;

  logic                        est_acc;
  logic                        in_sum;
  logic                        in_div;
  logic                        in_done;
  logic                        write_ok;
  logic                        div_ok;

  // Bucket fields of the incoming hash.
  always_comb begin
    eff_ib   = (index_bits > hll_pkg::IbW'(hll_pkg::MaxIndexBits)) ?
               hll_pkg::IbW'(hll_pkg::MaxIndexBits) : index_bits;
    counted  = hll_pkg::RegW'(hll_pkg::HashBits) - hll_pkg::RegW'(eff_ib);
    hash_low = s_tdata & ~({64{1'b1}} << counted);
    in_idx   = hll_pkg::AddrW'(s_tdata[63 -: hll_pkg::AddrW] >>
               (hll_pkg::IbW'(hll_pkg::MaxIndexBits) - eff_ib));
    in_cnt   = hll_pkg::tz_count(hash_low, counted);
  end

  assign cur_reg = valid_rd ? ram_rdata : '0;

  // 2^-reg in Q.64; a zero register contributes one.
  assign term = (cur_reg <= hll_pkg::RegW'(hll_pkg::FracBits)) ?
                (hll_pkg::SumW'(1) << (hll_pkg::RegW'(hll_pkg::FracBits) - cur_reg)) : '0;

  // One restoring division step.
  always_comb begin
    div_r2   = {rem, numq[hll_pkg::NumW-1]};
    div_diff = div_r2 - {1'b0, sum};
    div_bit  = (div_r2 >= {1'b0, sum});
  end

  assign est_sat  = (sum == '0) || (|numq[hll_pkg::NumW-1:64]);
  assign out_load = (state == hll_pkg::ST_DONE) && (!m_tvalid || m_tready);
  assign in_acc   = s_tvalid && s_tready;

  assign est_acc  = in_acc && (s_tuser == hll_pkg::OP_EST);
  assign in_sum   = (state == hll_pkg::ST_SUM);
  assign in_div   = (state == hll_pkg::ST_DIV);
  assign in_done  = (state == hll_pkg::ST_DONE);
  assign write_ok = (hold_cnt <= hll_pkg::RegW'(hll_pkg::HashBits)) && (hold_cnt > cur_reg);
  assign div_ok   = (div_cnt < hll_pkg::DivCntW'(hll_pkg::DivSteps));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      hll_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (s_tuser == hll_pkg::OP_ADD) ? hll_pkg::ST_ADD : hll_pkg::ST_SUM;
        end
      end
      hll_pkg::ST_ADD: state_next = hll_pkg::ST_IDLE;
      hll_pkg::ST_SUM: begin
        if (walk_idx == walk_last) state_next = hll_pkg::ST_DIV;
      end
      hll_pkg::ST_DIV: begin
        if (div_cnt == hll_pkg::DivCntW'(hll_pkg::DivSteps - 1)) state_next = hll_pkg::ST_DONE;
      end
      hll_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) state_next = hll_pkg::ST_IDLE;
      end
      default: state_next = hll_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    s_tready  = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = hold_idx;
    unique case (state)
      hll_pkg::ST_IDLE: begin
        s_tready  = 1'b1;
        ram_raddr = (s_tuser == hll_pkg::OP_ADD) ? in_idx : '0;
      end
      hll_pkg::ST_ADD:  ram_we = (cur_reg < hold_cnt);
      hll_pkg::ST_SUM:  ram_raddr = walk_idx + hll_pkg::AddrW'(1);
      hll_pkg::ST_DIV:  ram_raddr = hold_idx;
      hll_pkg::ST_DONE: ram_raddr = hold_idx;
      default:          ram_raddr = hold_idx;
    endcase
  end

  hll_ram #(
    .Width(hll_pkg::RegW),
    .Depth(hll_pkg::Buckets)
  ) u_bucket_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(hold_idx),
    .wdata(hold_cnt),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= hll_pkg::ST_IDLE;
      index_bits        <= hll_pkg::IndexBitsReset;
      estimate_constant <= hll_pkg::EstConstReset;
      valid             <= '0;
      valid_rd          <= 1'b0;
      m_tvalid          <= 1'b0;
    end else begin
      state    <= state_next;
      valid_rd <= valid[ram_raddr];
      if (cfg_we) begin
        case (cfg_addr)
          hll_pkg::CFG_INDEX_BITS: index_bits        <= cfg_data[hll_pkg::IbW-1:0];
          hll_pkg::CFG_EST_CONST:  estimate_constant <= cfg_data;
          default: ;
        endcase
      end
      if (ram_we) valid[hold_idx] <= 1'b1;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      hold_idx  <= in_idx;
      hold_cnt  <= in_cnt;
      sum       <= '0;
      walk_idx  <= '0;
      walk_last <= hll_pkg::AddrW'((9'd1 << eff_ib) - 9'd1);
    end
    if (state == hll_pkg::ST_SUM) begin
      sum      <= sum + term;
      walk_idx <= walk_idx + hll_pkg::AddrW'(1);
      if (walk_idx == walk_last) begin
        // numerator = C * m * m * 2^48
        numq    <= hll_pkg::NumW'(estimate_constant) << (7'd48 + {2'b00, eff_ib, 1'b0});
        rem     <= '0;
        div_cnt <= '0;
      end
    end
    if (state == hll_pkg::ST_DIV) begin
      rem     <= div_bit ? div_diff[hll_pkg::SumW-1:0] : div_r2[hll_pkg::SumW-1:0];
      numq    <= {numq[hll_pkg::NumW-2:0], div_bit};
      div_cnt <= div_cnt + hll_pkg::DivCntW'(1);
    end
    if (out_load) begin
      m_tdata <= est_sat ? {64{1'b1}} : numq[63:0];
      m_tuser <= est_sat;
    end
  end

  `ASSERT_CLK(a_est_starts_walk, clk, rst, est_acc |=> in_sum, "estimate skipped the walk")
  `ASSERT_CLK(a_out_from_done, clk, rst, $rose(m_tvalid) |-> $past(in_done), "result raised early")
  `ASSERT_IMPLY(a_write_bounded, clk, rst, ram_we, write_ok, "bucket write not a new maximum")
  `ASSERT_IMPLY(a_div_count, clk, rst, in_div, div_ok, "divider ran past its last step")

endmodule

>>> sv/hll_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module hll_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

>>> tb/testbench.sv
// Testbench for hyperloglog_sketch_unit: hash streams with an in-order estimate checker.
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [63:0] estimate;
    logic        saturated;
  } est_word_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;   // [63:0] hash_value
  logic        s_tuser;   // [0] op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;   // [63:0] estimate
  logic        m_tuser;   // [0] saturated
  logic        cfg_we;
  logic        cfg_addr;
  logic [15:0] cfg_data;

  // Shadow of the sketch: bucket maxima and the two configuration registers.
  logic [hll_pkg::RegW-1:0]   bucket_max [hll_pkg::Buckets];
  logic [hll_pkg::IbW-1:0]    index_bits_q;
  logic [hll_pkg::ConstW-1:0] est_const_q;
  est_word_t                  estimates_due [$];

  int mismatches = 0;
  bit src_idle_en = 1'b0;
  bit sink_stall_en = 1'b0;

  hyperloglog_sketch_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int active_index_bits();
    return (index_bits_q > hll_pkg::MaxIndexBits) ? hll_pkg::MaxIndexBits : int'(index_bits_q);
  endfunction

  // Keep the largest trailing-zero count seen per bucket.
  function automatic void record_hash(input logic [63:0] h);
    int ib;
    int counted;
    int zeros;
    logic [7:0] idx;
    ib = active_index_bits();
    counted = hll_pkg::HashBits - ib;
    idx = (ib == 0) ? 8'd0 : 8'(h >> counted);
    zeros = 0;
    while (zeros < counted && !h[zeros]) zeros++;
    if (bucket_max[idx] < zeros) bucket_max[idx] = hll_pkg::RegW'(zeros);
  endfunction

  // Sum 2^-reg in 64 fractional bits, then C*m*m/sum with C in Q0.16.
  function automatic est_word_t predict_estimate();
    int ib;
    int i;
    logic [127:0] sum;
    logic [127:0] num;
    logic [127:0] quo;
    logic [63:0]  m;
    est_word_t    w;
    ib = active_index_bits();
    m = 64'd1 << ib;
    sum = '0;
    for (i = 0; i < (1 << ib); i++) sum += 128'd1 << (64 - int'(bucket_max[i]));
    num = (128'(est_const_q) * m * m) << 48;
    if (sum == '0) begin
      w = '{estimate: '1, saturated: 1'b1};
    end else begin
      quo = num / sum;
      if (quo[127:64] != '0) w = '{estimate: '1, saturated: 1'b1};
      else w = '{estimate: quo[63:0], saturated: 1'b0};
    end
    return w;
  endfunction

  task automatic send_word(input logic op, input logic [63:0] hash);
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = hash;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op == hll_pkg::OP_ADD) record_hash(hash);
    else estimates_due.push_back(predict_estimate());
    @(negedge clk);
  endtask

  // Hold the sender until every estimate is back, then let a pending add finish.
  task automatic settle();
    s_tvalid = 1'b0;
    while (estimates_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_register(input logic addr, input logic [15:0] value);
    cfg_we   = 1'b1;
    cfg_addr = addr;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (addr == hll_pkg::CFG_INDEX_BITS) index_bits_q = value[hll_pkg::IbW-1:0];
    else est_const_q = value;
  endtask

  always @(posedge clk) begin
    est_word_t due;
    if (!rst && m_tvalid && m_tready) begin
      if (estimates_due.size() == 0) begin
        $error("estimate word with none pending: estimate %h saturated %b", m_tdata, m_tuser);
        mismatches++;
      end else begin
        due = estimates_due.pop_front();
        if (m_tdata !== due.estimate) begin
          $error("estimate: expected %h, got %h", due.estimate, m_tdata);
          mismatches++;
        end
        if (m_tuser !== due.saturated) begin
          $error("saturated: expected %b, got %b", due.saturated, m_tuser);
          mismatches++;
        end
      end
    end
  end

  // Stall the result side in bursts.
  always begin
    @(negedge clk);
    if (sink_stall_en && $urandom_range(0, 4) == 0) begin
      m_tready = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    m_tready = 1'b1;
  end

  task automatic test_empty_sketch();
    send_word(hll_pkg::OP_EST, 64'h0);
  endtask

  task automatic test_hash_extremes();
    send_word(hll_pkg::OP_ADD, 64'h0000_0000_0000_0000);
    send_word(hll_pkg::OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(hll_pkg::OP_ADD, 64'h0000_0000_0000_0001);
    send_word(hll_pkg::OP_ADD, 64'h8000_0000_0000_0000);
    send_word(hll_pkg::OP_ADD, 64'h0000_0000_0000_0100);
    send_word(hll_pkg::OP_ADD, 64'hF000_0000_0001_0000);
    send_word(hll_pkg::OP_ADD, 64'h7FFF_FFFF_FFFF_FFFE);
    send_word(hll_pkg::OP_EST, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_index_range();
    // one bucket: all 64 bits are counted
    settle();
    write_register(hll_pkg::CFG_INDEX_BITS, 16'd0);
    send_word(hll_pkg::OP_ADD, 64'h0);
    send_word(hll_pkg::OP_ADD, 64'h5555_5555_5555_5555);
    send_word(hll_pkg::OP_EST, 64'h0);
    // oversized width behaves as the widest index
    settle();
    write_register(hll_pkg::CFG_INDEX_BITS, 16'd15);
    send_word(hll_pkg::OP_ADD, 64'hFF00_0000_0000_0000);
    send_word(hll_pkg::OP_ADD, 64'h0100_0000_0000_0000);
    send_word(hll_pkg::OP_ADD, 64'hAB00_0000_0000_8000);
    send_word(hll_pkg::OP_EST, 64'h0);
  endtask

  task automatic test_saturation();
    // bucket 0 already holds 64; pushing bucket 1 to 63 leaves a sum of 3
    settle();
    write_register(hll_pkg::CFG_INDEX_BITS, 16'd1);
    write_register(hll_pkg::CFG_EST_CONST, 16'hFFFF);
    send_word(hll_pkg::OP_ADD, 64'h8000_0000_0000_0000);
    send_word(hll_pkg::OP_EST, 64'h0);
    settle();
    write_register(hll_pkg::CFG_EST_CONST, 16'h0000);
    send_word(hll_pkg::OP_EST, 64'h0);
  endtask

  task automatic test_random_stream();
    int phase;
    int n;
    int k;
    logic [hll_pkg::IbW-1:0] ib;
    logic [15:0]             c;
    logic [63:0]             h;
    logic [7:0]              top;
    for (phase = 0; phase < 12; phase++) begin
      case (phase)
        0: begin
          ib = hll_pkg::IbW'(hll_pkg::MaxIndexBits);
          c  = 16'hFFFF;
        end
        1: begin
          ib = '0;
          c  = 16'h0000;
        end
        2: begin
          ib = '1;
          c  = 16'($urandom);
        end
        3: begin
          ib = hll_pkg::IbW'(1);
          c  = hll_pkg::EstConstReset;
        end
        default: begin
          ib = hll_pkg::IbW'($urandom_range(0, 15));
          c  = 16'($urandom);
        end
      endcase
      settle();
      write_register(hll_pkg::CFG_INDEX_BITS, {12'b0, ib});
      write_register(hll_pkg::CFG_EST_CONST, c);
      src_idle_en   = (phase < 10);
      sink_stall_en = (phase < 10);
      for (n = 0; n < 152; n++) begin
        h = {$urandom, $urandom};
        if ($urandom_range(0, 7) == 0) begin
          send_word(hll_pkg::OP_EST, h);
        end else begin
          // deepen the trailing zeros while keeping the bucket bits random
          if ($urandom_range(0, 2) == 0) begin
            top = h[63:56];
            k = $urandom_range(0, 63);
            h = h & ~((64'd1 << k) - 64'd1);
            if (k == 63) h[55:0] = '0;
            h[63:56] = top;
          end
          send_word(hll_pkg::OP_ADD, h);
        end
      end
    end
  endtask

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = hll_pkg::OP_ADD;
    cfg_we       = 1'b0;
    cfg_addr     = hll_pkg::CFG_INDEX_BITS;
    cfg_data     = '0;
    index_bits_q = hll_pkg::IndexBitsReset;
    est_const_q  = hll_pkg::EstConstReset;
    foreach (bucket_max[i]) bucket_max[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    src_idle_en   = 1'b1;
    sink_stall_en = 1'b1;
    test_empty_sketch();
    test_hash_extremes();
    test_index_range();
    test_saturation();
    test_random_stream();

    settle();
    repeat (400) @(negedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
